>>> rtl/core/nocs_pkg.sv
// ----------------------------------------------------------------------------
// nocs_pkg
// Shared types and constants for the nearest open cell search block.
// ----------------------------------------------------------------------------
package nocs_pkg;

  // field and register widths
  localparam int COORD_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CAND_W     = 10;   // candidate coordinates, origin +/- 128
  localparam int RING_W     = 8;    // ring radius, up to 128
  localparam int OFF_W      = 9;    // signed row offset, -128 .. 128

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RADIUS = 2'd2;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] RST_MAP_WIDTH     = 7'd64;
  localparam logic [CFG_DATA_W-1:0] RST_MAP_HEIGHT    = 7'd64;
  localparam logic [CFG_DATA_W-1:0] RST_SEARCH_RADIUS = 7'd16;

  // item kinds
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  // control sequencer
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_PROBE,
    ST_CHECK,
    ST_FINISH
  } state_t;

endpackage

>>> rtl/core/nocs_bitmap.sv
// ----------------------------------------------------------------------------
// nocs_bitmap
// Occupancy bitmap storage, one row of cells per word, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module nocs_bitmap #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [$clog2(ROWS)-1:0] waddr,
  input  logic [COLS-1:0]         wdata,
  input  logic                    re,
  input  logic [$clog2(ROWS)-1:0] raddr,
  output logic [COLS-1:0]         rdata
);

  logic [COLS-1:0] mem [ROWS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/nearest_open_cell_search.sv
// ----------------------------------------------------------------------------
// nearest_open_cell_search
// Occupancy bitmap with a nearest open cell query over Manhattan rings.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  cfg      in         cfg_write           cfg_index, cfg_data
//  in       in         in_valid/in_stall   req_type, cell_x, cell_y, blocked_bit
//  out      out        out_valid/out_stall result_x, result_y, moved, found
//
//  A write item in bounds reads its row and writes it back; one off the map is ignored.
//  A query reads and checks each in-bounds cell probed (bitmap read port latency),
//  skips cells off the map without a read, and ends with a result;
//  one query is in flight at a time.
//  After reset the bitmap is cleared one row a cycle, with
//  in_stall high; configuration writes are taken throughout.
//  A finished result waits in the output register while the next item enters;
//  a query that completes with that register still full holds until it drains.
//
module nearest_open_cell_search #(
  parameter int MAP_SIDE = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write,
  input  logic [nocs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nocs_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 req_type,
  input  logic signed [nocs_pkg::COORD_W-1:0]  cell_x,
  input  logic signed [nocs_pkg::COORD_W-1:0]  cell_y,
  input  logic                                 blocked_bit,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [nocs_pkg::COORD_W-1:0]  result_x,
  output logic signed [nocs_pkg::COORD_W-1:0]  result_y,
  output logic                                 moved,
  output logic                                 found
);

  localparam int AW = $clog2(MAP_SIDE);
  localparam int CW = nocs_pkg::CAND_W;
  localparam int DW = nocs_pkg::CFG_DATA_W;
  localparam logic [DW-1:0] SIDE_DIM = DW'(MAP_SIDE);
  localparam logic [AW-1:0] LAST_ROW = AW'(MAP_SIDE - 1);

  nocs_pkg::state_t state, state_next;

  // configuration registers
  logic [DW-1:0] map_width;
  logic [DW-1:0] map_height;
  logic [DW-1:0] search_radius;

  // clearing pass
  logic [AW-1:0] clr_row;

  // search state
  logic [nocs_pkg::COORD_W-1:0] org_x;
  logic [nocs_pkg::COORD_W-1:0] org_y;
  logic [nocs_pkg::RING_W-1:0]  ring;
  logic [nocs_pkg::OFF_W-1:0]   row_off;
  logic                         side;
  logic                         hit;
  logic [nocs_pkg::COORD_W-1:0] hit_x;
  logic [nocs_pkg::COORD_W-1:0] hit_y;

  // pending cell write
  logic [AW-1:0] wr_row;
  logic [AW-1:0] wr_col;
  logic          wr_val;

  // bitmap port signals
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [MAP_SIDE-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [MAP_SIDE-1:0] mem_rdata;
  logic [MAP_SIDE-1:0] row_mod;

  // combinational helpers
  logic [DW-1:0]                eff_w;
  logic [DW-1:0]                eff_h;
  logic [nocs_pkg::OFF_W-1:0]   abs_off;
  logic [CW-1:0]                col_off;
  logic [CW-1:0]                cand_x;
  logic [CW-1:0]                cand_y;
  logic                         cand_in;
  logic [CW-1:0]                wx;
  logic [CW-1:0]                wy;
  logic                         w_in;
  logic                         ring_over;
  logic                         cell_open;
  logic                         accept;
  logic                         out_free;
  logic                         load_out;
  logic [nocs_pkg::RING_W-1:0]  adv_ring;
  logic [nocs_pkg::OFF_W-1:0]   adv_off;
  logic                         adv_side;

  // bitmap storage
  nocs_bitmap #(
    .ROWS (MAP_SIDE),
    .COLS (MAP_SIDE)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // effective map bounds
  assign eff_w = (map_width  > SIDE_DIM) ? SIDE_DIM : map_width;
  assign eff_h = (map_height > SIDE_DIM) ? SIDE_DIM : map_height;

  // current candidate cell from ring, row offset and side
  assign abs_off = row_off[nocs_pkg::OFF_W-1] ? (~row_off + 1'b1) : row_off;
  assign col_off = {2'b00, ring} - {1'b0, abs_off};
  assign cand_x  = {{2{org_x[7]}}, org_x} + (side ? col_off : (~col_off + 1'b1));
  assign cand_y  = {{2{org_y[7]}}, org_y} + {row_off[nocs_pkg::OFF_W-1], row_off};
  assign cand_in = !cand_x[CW-1] && !cand_y[CW-1] &&
                   (cand_x < {3'b000, eff_w}) && (cand_y < {3'b000, eff_h});

  // bounds of an incoming cell write
  assign wx   = {{2{cell_x[7]}}, cell_x};
  assign wy   = {{2{cell_y[7]}}, cell_y};
  assign w_in = !wx[CW-1] && !wy[CW-1] &&
                (wx < {3'b000, eff_w}) && (wy < {3'b000, eff_h});

  assign ring_over = ({1'b0, search_radius} < ring);
  assign cell_open = !mem_rdata[cand_x[AW-1:0]];
  assign accept    = in_valid && (state == nocs_pkg::ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // next cell in scan order: left then right, row offset upwards, then next ring
  always_comb begin
    adv_ring = ring;
    adv_off  = row_off;
    adv_side = 1'b1;
    if (side) begin
      adv_side = 1'b0;
      if (row_off == {1'b0, ring}) begin
        adv_ring = ring + 1'b1;
        adv_off  = ~{1'b0, ring};  // -(ring + 1)
      end else begin
        adv_off  = row_off + 1'b1;
      end
    end
  end

  // row with the pending cell bit replaced
  always_comb begin
    for (int i = 0; i < MAP_SIDE; i++) begin
      row_mod[i] = (wr_col == AW'(i)) ? wr_val : mem_rdata[i];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nocs_pkg::ST_CLEAR: begin
        if (clr_row == LAST_ROW) state_next = nocs_pkg::ST_IDLE;
      end
      nocs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (req_type == nocs_pkg::REQ_QUERY) begin
            state_next = nocs_pkg::ST_PROBE;
          end else if (w_in) begin
            state_next = nocs_pkg::ST_WRITE;
          end
        end
      end
      nocs_pkg::ST_WRITE: begin
        state_next = nocs_pkg::ST_IDLE;
      end
      nocs_pkg::ST_PROBE: begin
        if (ring_over) begin
          state_next = nocs_pkg::ST_FINISH;
        end else if (cand_in) begin
          state_next = nocs_pkg::ST_CHECK;
        end
      end
      nocs_pkg::ST_CHECK: begin
        state_next = cell_open ? nocs_pkg::ST_FINISH : nocs_pkg::ST_PROBE;
      end
      nocs_pkg::ST_FINISH: begin
        if (out_free) state_next = nocs_pkg::ST_IDLE;
      end
      default: begin
        state_next = nocs_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = clr_row;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cand_y[AW-1:0];
    load_out  = 1'b0;
    case (state)
      nocs_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      nocs_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        mem_raddr = wy[AW-1:0];
        mem_re    = in_valid && (req_type == nocs_pkg::REQ_WRITE) && w_in;
      end
      nocs_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_row;
        mem_wdata = row_mod;
      end
      nocs_pkg::ST_PROBE: begin
        mem_re = !ring_over && cand_in;
      end
      nocs_pkg::ST_FINISH: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= nocs_pkg::ST_CLEAR;
      clr_row       <= '0;
      map_width     <= nocs_pkg::RST_MAP_WIDTH;
      map_height    <= nocs_pkg::RST_MAP_HEIGHT;
      search_radius <= nocs_pkg::RST_SEARCH_RADIUS;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == nocs_pkg::ST_CLEAR) clr_row <= clr_row + 1'b1;
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          nocs_pkg::REG_MAP_WIDTH:     map_width     <= cfg_data;
          nocs_pkg::REG_MAP_HEIGHT:    map_height    <= cfg_data;
          nocs_pkg::REG_SEARCH_RADIUS: search_radius <= cfg_data;
          default: begin
          end
        endcase
      end
      // output register occupancy
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search and payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      org_x   <= cell_x;
      org_y   <= cell_y;
      ring    <= '0;
      row_off <= '0;
      side    <= 1'b1;   // origin is tried once, then the scan moves to ring one
      hit     <= 1'b0;
      wr_row  <= wy[AW-1:0];
      wr_col  <= wx[AW-1:0];
      wr_val  <= blocked_bit;
    end
    // skip cells off the map without a read
    if (state == nocs_pkg::ST_PROBE && !ring_over && !cand_in) begin
      ring    <= adv_ring;
      row_off <= adv_off;
      side    <= adv_side;
    end
    // examine the read cell
    if (state == nocs_pkg::ST_CHECK) begin
      if (cell_open) begin
        hit   <= 1'b1;
        hit_x <= cand_x[nocs_pkg::COORD_W-1:0];
        hit_y <= cand_y[nocs_pkg::COORD_W-1:0];
      end else begin
        ring    <= adv_ring;
        row_off <= adv_off;
        side    <= adv_side;
      end
    end
    // result item
    if (load_out) begin
      result_x <= hit ? hit_x : org_x;
      result_y <= hit ? hit_y : org_y;
      moved    <= hit && ((hit_x != org_x) || (hit_y != org_y));
      found    <= hit;
    end
  end

  // read data is only examined the cycle after a probe issued the read
  assert property (@(posedge clk) disable iff (rst)
    state == nocs_pkg::ST_CHECK |-> $past(state) == nocs_pkg::ST_PROBE)
    else $error("cell check without a preceding bitmap read");

  // a query holds the input side until it completes
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == nocs_pkg::REQ_QUERY |=> in_stall)
    else $error("input taken while a query is in flight");

  // a cell other than the origin is only returned from inside the map
  assert property (@(posedge clk) disable iff (rst)
    out_valid && found && moved |-> !result_x[7] && !result_y[7])
    else $error("moved result lies outside the map");

endmodule
